### design/arc_pkg.sv
// Shared constants and types for the adaptive resolution controller.
// No dependencies; used by the top level and its checker.
package arc_pkg;

  // Default widths
  localparam int TIME_BITS_DEF  = 20;
  localparam int COUNT_BITS_DEF = 16;

  // Scale is Q16, 65536 = 1.0
  localparam int SCALE_BITS = 17;
  localparam int OUT_DATA_W = ((SCALE_BITS + 7) / 8) * 8;

  // Q16 coefficients, truncated
  localparam int unsigned K_KEEP   = 62259;  // 0.95
  localparam int unsigned K_NEW    = 3276;   // 0.05
  localparam int unsigned K_SLOW   = 58982;  // 0.90
  localparam int unsigned K_FAST   = 45875;  // 0.70
  localparam int unsigned K_SHRINK = 58982;  // 0.90
  localparam int unsigned K_GROW   = 69468;  // 1.06

  // Register reset values
  localparam int unsigned RST_BUDGET   = 16667;
  localparam int unsigned RST_WARMUP   = 0;
  localparam int unsigned RST_DOWN     = 12;
  localparam int unsigned RST_UP       = 240;
  localparam int unsigned RST_COOLDOWN = 240;
  localparam int unsigned RST_FLOOR    = 19661;
  localparam int unsigned RST_CEILING  = 49152;
  localparam int unsigned RST_START    = 32768;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_BUDGET    = 3'd0,
    CFG_WARMUP_COUNT    = 3'd1,
    CFG_DOWN_COUNT      = 3'd2,
    CFG_UP_COUNT        = 3'd3,
    CFG_COOLDOWN_LENGTH = 3'd4,
    CFG_SCALE_FLOOR     = 3'd5,
    CFG_SCALE_CEILING   = 3'd6,
    CFG_START_SCALE     = 3'd7
  } cfg_idx_t;

endpackage

### design/adaptive_resolution_controller.sv
// Adaptive resolution controller: render-time average, slow/fast run counters and scale update.
// Depends on arc_pkg.
//
// Takes one frame render time per transaction and returns one transaction per frame:
// the resized flag and the Q16 scale in force after that frame. Items are accepted
// every cycle while results are taken and no reinitialisation is pending; each passes
// the input register and the update logic into the output register. The output
// register lets the next item in while a result waits. Throughput is one item per
// clock under the same conditions, set by updating the average, counters and scale
// together. A configuration write (always accepted) sets init_pending_r, which holds
// in_tready low; the state is then reinitialised from the registers and the flag
// cleared. Reset sets the flag as well.
module adaptive_resolution_controller #(
  parameter int TIME_BITS  = arc_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = arc_pkg::COUNT_BITS_DEF,
  localparam int InW  = ((TIME_BITS + 7) / 8) * 8,
  localparam int CfgW = (TIME_BITS > COUNT_BITS)
                        ? ((TIME_BITS > arc_pkg::SCALE_BITS) ? TIME_BITS : arc_pkg::SCALE_BITS)
                        : ((COUNT_BITS > arc_pkg::SCALE_BITS) ? COUNT_BITS : arc_pkg::SCALE_BITS)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [InW-1:0]                     in_tdata,   // [TIME_BITS-1:0] render_time
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [arc_pkg::OUT_DATA_W-1:0]     out_tdata,  // [16:0] scale
  output logic                               out_tuser,  // [0] resized
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [arc_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [CfgW-1:0]                    cfg_data
);

  localparam int SB    = arc_pkg::SCALE_BITS;
  localparam int AvgW  = TIME_BITS + 8;
  localparam int ProdW = TIME_BITS + 24;
  localparam int SProdW = 2 * SB;

  // Configuration registers
  logic [TIME_BITS-1:0]  budget_r;
  logic [COUNT_BITS-1:0] warmup_r, down_r, up_r, cooldown_r;
  logic [SB-1:0]         floor_r, ceiling_r, start_r;

  // State
  logic                  init_pending_r;
  logic [AvgW-1:0]       avg_r, slow_thr_r, fast_thr_r;
  logic [SB-1:0]         scale_r;
  logic [COUNT_BITS-1:0] seen_r, hold_r, slow_run_r, fast_run_r;

  // Pipeline
  logic                  s1_valid_r;
  logic [TIME_BITS-1:0]  rt_r;
  logic                  out_valid_r;
  logic                  resized_r;
  logic [SB-1:0]         out_scale_r;

  logic advance;
  logic cfg_wr;

  // Next-state logic
  logic [ProdW-1:0]      keep_prod, new_prod, avg_sum;
  logic [ProdW-1:0]      slow_prod, fast_prod;
  logic [SProdW-1:0]     shrink_prod, grow_prod;
  logic [SB-1:0]         shrink_val, start_clamped;
  logic [SB:0]           grow_raw;
  logic [SB-1:0]         grow_val;
  logic [AvgW-1:0]       avg_nxt;
  logic [SB-1:0]         scale_nxt;
  logic [COUNT_BITS-1:0] seen_nxt, hold_nxt, slow_run_nxt, fast_run_nxt;
  logic [COUNT_BITS-1:0] hold_dec, slow_inc, fast_inc;
  logic                  resized_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign advance    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready  = ~init_pending_r & (~s1_valid_r | advance);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = resized_r;
  assign out_tdata  = arc_pkg::OUT_DATA_W'(out_scale_r);

  // Thresholds and start scale, taken at the init cycle
  assign slow_prod = ProdW'({budget_r, 8'b0}) * ProdW'(arc_pkg::K_SLOW);
  assign fast_prod = ProdW'({budget_r, 8'b0}) * ProdW'(arc_pkg::K_FAST);

  always_comb begin
    start_clamped = start_r;
    if (start_clamped > ceiling_r) start_clamped = ceiling_r;
    if (start_clamped < floor_r) start_clamped = floor_r;
  end

  // Average update
  assign keep_prod = ProdW'(avg_r) * ProdW'(arc_pkg::K_KEEP);
  assign new_prod  = ProdW'({rt_r, 8'b0}) * ProdW'(arc_pkg::K_NEW);
  assign avg_sum   = keep_prod + new_prod;
  assign avg_nxt   = avg_sum[ProdW-1:16];

  // Candidate scales, from the current scale in parallel with the average
  assign shrink_prod = SProdW'(scale_r) * SProdW'(arc_pkg::K_SHRINK);
  assign grow_prod   = SProdW'(scale_r) * SProdW'(arc_pkg::K_GROW);
  assign shrink_val  = (shrink_prod[SProdW-2:16] < floor_r) ? floor_r : shrink_prod[SProdW-2:16];
  assign grow_raw    = grow_prod[SProdW-1:16];
  assign grow_val    = (grow_raw > {1'b0, ceiling_r}) ? ceiling_r : grow_raw[SB-1:0];

  assign hold_dec = (hold_r != '0) ? hold_r - COUNT_BITS'(1) : hold_r;
  assign slow_inc = (slow_run_r == '1) ? slow_run_r : slow_run_r + COUNT_BITS'(1);
  assign fast_inc = (fast_run_r == '1) ? fast_run_r : fast_run_r + COUNT_BITS'(1);

  always_comb begin
    seen_nxt     = (seen_r == '1) ? seen_r : seen_r + COUNT_BITS'(1);
    hold_nxt     = hold_dec;
    slow_run_nxt = slow_run_r;
    fast_run_nxt = fast_run_r;
    scale_nxt    = scale_r;
    resized_nxt  = 1'b0;
    if (seen_nxt > warmup_r && hold_dec == '0) begin
      if (avg_nxt > slow_thr_r) begin
        fast_run_nxt = '0;
        slow_run_nxt = slow_inc;
        if (slow_inc >= down_r && scale_r > floor_r) begin
          scale_nxt    = shrink_val;
          slow_run_nxt = '0;
          hold_nxt     = cooldown_r;
          resized_nxt  = 1'b1;
        end
      end else if (avg_nxt < fast_thr_r) begin
        slow_run_nxt = '0;
        fast_run_nxt = fast_inc;
        if (fast_inc >= up_r && scale_r < ceiling_r) begin
          scale_nxt    = grow_val;
          fast_run_nxt = '0;
          hold_nxt     = cooldown_r;
          resized_nxt  = 1'b1;
        end
      end else begin
        slow_run_nxt = '0;
        fast_run_nxt = '0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r   <= TIME_BITS'(arc_pkg::RST_BUDGET);
      warmup_r   <= COUNT_BITS'(arc_pkg::RST_WARMUP);
      down_r     <= COUNT_BITS'(arc_pkg::RST_DOWN);
      up_r       <= COUNT_BITS'(arc_pkg::RST_UP);
      cooldown_r <= COUNT_BITS'(arc_pkg::RST_COOLDOWN);
      floor_r    <= SB'(arc_pkg::RST_FLOOR);
      ceiling_r  <= SB'(arc_pkg::RST_CEILING);
      start_r    <= SB'(arc_pkg::RST_START);
    end else if (cfg_wr) begin
      unique case (arc_pkg::cfg_idx_t'(cfg_addr))
        arc_pkg::CFG_FRAME_BUDGET:    budget_r   <= cfg_data[TIME_BITS-1:0];
        arc_pkg::CFG_WARMUP_COUNT:    warmup_r   <= cfg_data[COUNT_BITS-1:0];
        arc_pkg::CFG_DOWN_COUNT:      down_r     <= cfg_data[COUNT_BITS-1:0];
        arc_pkg::CFG_UP_COUNT:        up_r       <= cfg_data[COUNT_BITS-1:0];
        arc_pkg::CFG_COOLDOWN_LENGTH: cooldown_r <= cfg_data[COUNT_BITS-1:0];
        arc_pkg::CFG_SCALE_FLOOR:     floor_r    <= cfg_data[SB-1:0];
        arc_pkg::CFG_SCALE_CEILING:   ceiling_r  <= cfg_data[SB-1:0];
        arc_pkg::CFG_START_SCALE:     start_r    <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  // Controller state; reinitialised through init_pending_r after reset or any register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_pending_r <= 1'b1;
      seen_r         <= '0;
      hold_r         <= '0;
      slow_run_r     <= '0;
      fast_run_r     <= '0;
    end else if (cfg_wr) begin
      init_pending_r <= 1'b1;
    end else if (init_pending_r) begin
      init_pending_r <= 1'b0;
      avg_r          <= {budget_r, 8'b0};
      slow_thr_r     <= slow_prod[ProdW-1:16];
      fast_thr_r     <= fast_prod[ProdW-1:16];
      scale_r        <= start_clamped;
      seen_r         <= '0;
      hold_r         <= '0;
      slow_run_r     <= '0;
      fast_run_r     <= '0;
    end else if (advance) begin
      avg_r      <= avg_nxt;
      scale_r    <= scale_nxt;
      seen_r     <= seen_nxt;
      hold_r     <= hold_nxt;
      slow_run_r <= slow_run_nxt;
      fast_run_r <= fast_run_nxt;
    end
  end

  // Input register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rt_r <= in_tdata[TIME_BITS-1:0];
    end
    if (advance) begin
      resized_r   <= resized_nxt;
      out_scale_r <= scale_nxt;
    end
  end

endmodule

### design/arc_checker.sv
// Port-level checks for the adaptive resolution controller, bound to the top level.
// Depends on arc_pkg.
module arc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [arc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                             out_tuser,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  // a stalled result transaction stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // and its payload does not move
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // state reinit cycle after a register write takes no input
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input taken during reinitialisation");

  // an item taken with the output empty is followed by an offered result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing two cycles after acceptance");

endmodule

bind adaptive_resolution_controller arc_checker u_arc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for adaptive_resolution_controller: render-time streams against a
// built-in scale predictor, under several register settings. Needs arc_pkg and the top level.
module testbench;

  localparam int TIME_W = 20;
  localparam int CFG_W  = 20;
  localparam int IN_W   = 24;
  localparam longint unsigned TIME_MAX  = (64'd1 << TIME_W) - 1;
  localparam longint unsigned COUNT_MAX = 65535;
  localparam longint unsigned SCALE_MSK = (64'd1 << arc_pkg::SCALE_BITS) - 1;
  localparam longint unsigned AVG_MSK   = (64'd1 << (TIME_W + 8)) - 1;
  // Q16 weights, truncated
  localparam longint unsigned Q_OLD    = 62259;
  localparam longint unsigned Q_FRESH  = 3276;
  localparam longint unsigned Q_SLOW   = 58982;
  localparam longint unsigned Q_FAST   = 45875;
  localparam longint unsigned Q_SHRINK = 58982;
  localparam longint unsigned Q_GROW   = 69468;
  localparam int SETTINGS_TOTAL = 20;

  typedef enum {PACE_SLOW, PACE_FAST, PACE_NEAR, PACE_WILD} pace_t;

  class scale_scoreboard;
    typedef struct {
      bit                           resized;
      bit [arc_pkg::SCALE_BITS-1:0] scale;
    } frame_result_t;

    longint unsigned budget, warmup, down_len, up_len, cooldown;
    longint unsigned scale_floor, scale_ceil, scale_start;
    longint unsigned avg, scale, seen, hold, slow_run, fast_run;
    frame_result_t   pending_scales[$];
    int              errors, frames, shrinks, grows;

    function new();
      budget      = 16667;
      warmup      = 0;
      down_len    = 12;
      up_len      = 240;
      cooldown    = 240;
      scale_floor = 19661;
      scale_ceil  = 49152;
      scale_start = 32768;
      restart();
    endfunction

    function void restart();
      avg = (budget << 8) & AVG_MSK;
      scale = scale_start;
      // ceiling first, floor last: floor wins when they cross
      if (scale > scale_ceil) scale = scale_ceil;
      if (scale < scale_floor) scale = scale_floor;
      seen     = 0;
      hold     = 0;
      slow_run = 0;
      fast_run = 0;
    endfunction

    function void write_register(arc_pkg::cfg_idx_t idx, longint unsigned value);
      case (idx)
        arc_pkg::CFG_FRAME_BUDGET:    budget      = value & TIME_MAX;
        arc_pkg::CFG_WARMUP_COUNT:    warmup      = value & COUNT_MAX;
        arc_pkg::CFG_DOWN_COUNT:      down_len    = value & COUNT_MAX;
        arc_pkg::CFG_UP_COUNT:        up_len      = value & COUNT_MAX;
        arc_pkg::CFG_COOLDOWN_LENGTH: cooldown    = value & COUNT_MAX;
        arc_pkg::CFG_SCALE_FLOOR:     scale_floor = value & SCALE_MSK;
        arc_pkg::CFG_SCALE_CEILING:   scale_ceil  = value & SCALE_MSK;
        arc_pkg::CFG_START_SCALE:     scale_start = value & SCALE_MSK;
        default: ;
      endcase
      restart();
    endfunction

    function void note_frame(bit [TIME_W-1:0] render_time);
      longint unsigned rt, slow_lim, fast_lim, next_scale;
      frame_result_t   res;
      rt = render_time;
      slow_lim = ((budget << 8) * Q_SLOW) >> 16;
      fast_lim = ((budget << 8) * Q_FAST) >> 16;
      res.resized = 1'b0;
      avg = ((avg * Q_OLD + (rt << 8) * Q_FRESH) >> 16) & AVG_MSK;
      if (seen < COUNT_MAX) seen++;
      if (hold > 0) hold--;
      if (seen > warmup && hold == 0) begin
        if (avg > slow_lim) begin
          fast_run = 0;
          if (slow_run < COUNT_MAX) slow_run++;
          // a zero run length behaves as one
          if (slow_run >= down_len && scale > scale_floor) begin
            next_scale = (scale * Q_SHRINK) >> 16;
            if (next_scale < scale_floor) next_scale = scale_floor;
            scale = next_scale & SCALE_MSK;
            slow_run = 0;
            hold = cooldown;
            res.resized = 1'b1;
            shrinks++;
          end
        end else if (avg < fast_lim) begin
          slow_run = 0;
          if (fast_run < COUNT_MAX) fast_run++;
          if (fast_run >= up_len && scale < scale_ceil) begin
            next_scale = (scale * Q_GROW) >> 16;
            if (next_scale > scale_ceil) next_scale = scale_ceil;
            scale = next_scale & SCALE_MSK;
            fast_run = 0;
            hold = cooldown;
            // flagged even if truncation leaves the scale where it was
            res.resized = 1'b1;
            grows++;
          end
        end else begin
          slow_run = 0;
          fast_run = 0;
        end
      end
      res.scale = scale[arc_pkg::SCALE_BITS-1:0];
      pending_scales.push_back(res);
      frames++;
    endfunction

    function void check_result(bit got_resized, bit [arc_pkg::SCALE_BITS-1:0] got_scale);
      frame_result_t want;
      if (pending_scales.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected result, expected none, got resized=%0d scale=%0d",
                   $time, got_resized, got_scale);
        return;
      end
      want = pending_scales.pop_front();
      if (want.resized != got_resized) begin
        errors++;
        if (errors <= 100)
          $display("%0t: resized mismatch, expected %0d, got %0d",
                   $time, want.resized, got_resized);
      end
      if (want.scale != got_scale) begin
        errors++;
        if (errors <= 100)
          $display("%0t: scale mismatch, expected %0d, got %0d", $time, want.scale, got_scale);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [IN_W-1:0]                  in_tdata   = '0;   // [19:0] render_time
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [arc_pkg::OUT_DATA_W-1:0]   out_tdata;         // [16:0] scale
  logic                             out_tuser;         // [0] resized
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [arc_pkg::CFG_IDX_BITS-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]                 cfg_data   = '0;

  scale_scoreboard sb = new();
  int gap_pct   = 25;
  int stall_pct = 66;
  int settings_used = 0;
  bit [TIME_W-1:0] opening_frames [14] = '{
    20'd0, 20'hFFFFF, 20'd1, 20'h55555, 20'hAAAAA, 20'd16667, 20'd15000, 20'd11667,
    20'd16666, 20'd11666, 20'h80000, 20'h7FFFF, 20'd2, 20'hFFFFE
  };

  adaptive_resolution_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: sample pre-edge values, then pick the next ready
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[arc_pkg::SCALE_BITS-1:0]);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic send_frame(bit [TIME_W-1:0] render_time);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-TIME_W){1'b0}}, render_time};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_frame(render_time);
  endtask

  function automatic bit [TIME_W-1:0] frame_time(pace_t pace);
    longint unsigned b, t;
    b = sb.budget;
    case (pace)
      PACE_SLOW: t = b + b * $urandom_range(10, 100) / 100;
      PACE_FAST: t = b * $urandom_range(0, 60) / 100;
      PACE_NEAR: t = b * $urandom_range(65, 95) / 100;
      default:   t = $urandom & TIME_MAX;
    endcase
    if (t > TIME_MAX) t = TIME_MAX;
    return t[TIME_W-1:0];
  endfunction

  // bursts of one pace, so the average settles and runs build up
  task automatic run_frames(int n);
    int    left, burst, pick;
    pace_t pace;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      pace = (pick < 35) ? PACE_SLOW : (pick < 70) ? PACE_FAST :
             (pick < 85) ? PACE_NEAR : PACE_WILD;
      burst = $urandom_range(1, (pace == PACE_FAST) ? 40 : 25);
      if (burst > left) burst = left;
      repeat (burst) send_frame(frame_time(pace));
      left -= burst;
    end
  endtask

  task automatic write_reg(arc_pkg::cfg_idx_t idx, longint unsigned value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, value);
  endtask

  task automatic apply_settings(longint unsigned budget, longint unsigned warmup,
                                longint unsigned down_len, longint unsigned up_len,
                                longint unsigned cooldown, longint unsigned flr,
                                longint unsigned ceil, longint unsigned start);
    int mode;
    in_tvalid <= 1'b0;
    while (sb.pending_scales.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(arc_pkg::CFG_FRAME_BUDGET, budget);
    write_reg(arc_pkg::CFG_WARMUP_COUNT, warmup);
    write_reg(arc_pkg::CFG_DOWN_COUNT, down_len);
    write_reg(arc_pkg::CFG_UP_COUNT, up_len);
    write_reg(arc_pkg::CFG_COOLDOWN_LENGTH, cooldown);
    write_reg(arc_pkg::CFG_SCALE_FLOOR, flr);
    write_reg(arc_pkg::CFG_SCALE_CEILING, ceil);
    write_reg(arc_pkg::CFG_START_SCALE, start);
    cfg_valid <= 1'b0;
    settings_used++;
    mode = settings_used * 3 / SETTINGS_TOTAL;
    gap_pct   = (mode == 0) ? 25 : (mode == 1) ? 66 : 0;
    stall_pct = (mode == 0) ? 66 : (mode == 1) ? 25 : 0;
  endtask

  initial begin
    longint unsigned budget, flr, ceil, start, tmp;
    int              pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes, threshold edges, then a run of frames at the largest render time
    foreach (opening_frames[i]) send_frame(opening_frames[i]);
    repeat (8) send_frame(TIME_MAX[TIME_W-1:0]);

    apply_settings(1000, 0, 1, 1, 0, 655, 65536, 32768);          run_frames(120);
    apply_settings(1, 0, 0, 0, 0, 655, 65536, 65536);             run_frames(80);
    apply_settings(TIME_MAX, 3, 2, 3, 1, 19661, 49152, 100);      run_frames(80);
    apply_settings(0, 0, 1, 1, 0, 655, 65536, 40000);             run_frames(60);
    apply_settings(5000, 0, 1, 1, 2, 40000, 30000, 35000);        run_frames(60);
    apply_settings(5000, COUNT_MAX, 1, 1, 0, 655, 65536, 30000);  run_frames(60);
    apply_settings(3000, 0, 2, 2, 0, 30000, 30000, 50000);        run_frames(60);
    apply_settings(2000, 0, 1, 1, COUNT_MAX, 655, 65536, 20000);  run_frames(60);
    apply_settings(800, 2, COUNT_MAX, COUNT_MAX, 3, 655, 65536, 655); run_frames(60);

    repeat (SETTINGS_TOTAL - 10) begin
      pick = $urandom_range(9);
      budget = (pick == 0) ? TIME_MAX : (pick == 1) ? $urandom_range(1, 50)
                                                    : $urandom_range(100, 60000);
      flr  = $urandom_range(655, 50000);
      ceil = $urandom_range(flr, 65536);
      if ($urandom_range(7) == 0) begin
        tmp = flr;
        flr = ceil;
        ceil = tmp;
      end
      start = $urandom_range(655, 65536);
      apply_settings(budget, $urandom_range(0, 10), $urandom_range(0, 6),
                     $urandom_range(0, 12), $urandom_range(0, 5), flr, ceil, start);
      run_frames(125);
    end

    in_tvalid <= 1'b0;
    while (sb.pending_scales.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d frames under %0d register settings: %0d shrinks, %0d grows",
             sb.frames, settings_used + 1, sb.shrinks, sb.grows);
    if (sb.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
